// File: hdl/bounded_sorted_list_defines.svh
// ----------------------------------------------------------------------------
// bounded sorted list assertion macros
// shared assertion forms, sampled on clock and muted while reset is high
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SORTED_LIST_DEFINES_SVH
`define BOUNDED_SORTED_LIST_DEFINES_SVH

// consequent must hold in the same cycle
`define BSL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the following cycle
`define BSL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// shared constants and codes of the bounded sorted list
// ----------------------------------------------------------------------------
package bsl_pkg;

   // build defaults
   localparam int DEPTH_DEF     = 64;
   localparam int ID_BITS_DEF   = 32;
   localparam int SIZE_BITS_DEF = 40;

   // fixed field widths
   localparam int ID_W      = 32;
   localparam int TIME_W    = 64;
   localparam int SIZE_W    = 40;
   localparam int TOTAL_W   = 46;
   localparam int POS_W     = 6;
   localparam int CAP_W     = 7;
   localparam int COUNT_W   = 7;
   localparam int STATUS_W  = 3;

   localparam logic [CAP_W-1:0]   CAP_RESET = 7'd64;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // operation codes
   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_DROP      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_UNDERFLOW = 3'd4
   } status_type;

endpackage

// File: hdl/bsl_ram.sv
// ----------------------------------------------------------------------------
// bsl_ram
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bsl_ram #(
   parameter int DEPTH = bsl_pkg::DEPTH_DEF,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import bsl_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bounded_sorted_list.sv
// ----------------------------------------------------------------------------
// bounded_sorted_list
// table of (id, time, size) entries kept in descending time order, bounded by
// a capacity register, with a saturating running total of entry sizes
// ----------------------------------------------------------------------------
//
// channel | direction | handshake            | word
// --------+-----------+----------------------+----------------------------------
// req     | in        | req_valid/req_ready  | action, item id, time, size
// rsp     | out       | rsp_valid/rsp_ready  | status, position, eviction, totals
// csr     | in        | csr_valid/csr_ready  | capacity
//
// an add walks the table from the tail toward the head, one entry per cycle,
// shifting entries down until its slot is found. a remove walks from the
// head to the matching id, then shifts the rest up one entry per cycle. both
// are paced by the single read port of the entry memory. req_ready is high
// only while the sequencer is idle; a finished word waits in the rsp register
// and the next request is taken meanwhile. reset clears count, total and
// capacity (64); the entry memory is not cleared, only entries below count
// are ever read.
//
module bounded_sorted_list #(
   parameter int DEPTH     = bsl_pkg::DEPTH_DEF,
   parameter int ID_BITS   = bsl_pkg::ID_BITS_DEF,
   parameter int SIZE_BITS = bsl_pkg::SIZE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [bsl_pkg::ID_W-1:0]      req_item_id,
   input  logic signed [bsl_pkg::TIME_W-1:0] req_item_time,
   input  logic [bsl_pkg::SIZE_W-1:0]    req_item_size,
   // response
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bsl_pkg::POS_W-1:0]     rsp_position,
   output logic                          rsp_evicted,
   output logic [bsl_pkg::ID_W-1:0]      rsp_evicted_id,
   output logic [bsl_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic [bsl_pkg::TOTAL_W-1:0]   rsp_total_size,
   // capacity register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsl_pkg::CAP_W-1:0]     csr_capacity
);
   import bsl_pkg::*;

   `include "bounded_sorted_list_defines.svh"

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int SUM_W = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
   localparam int ENT_W = ID_BITS + TIME_W + SIZE_BITS;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_ADD_SCAN  = 7'b0000010,
      S_ADD_INS   = 7'b0000100,
      S_REM_SCAN  = 7'b0001000,
      S_REM_SHIFT = 7'b0010000,
      S_FIN       = 7'b0100000,
      S_SPARE     = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic                  full_ff, full_in;
   logic                  first_ff, first_in;
   status_type            status_ff, status_in;
   logic                  evicted_ff, evicted_in;
   logic [ID_BITS-1:0]    ev_id_ff, ev_id_in;

   // captured request word
   logic [ID_BITS-1:0]    item_id_ff, item_id_in;
   logic [TIME_W-1:0]     item_time_ff, item_time_in;
   logic [SIZE_BITS-1:0]  item_size_ff, item_size_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [POS_W-1:0]      rsp_position_ff;
   logic                  rsp_evicted_ff;
   logic [ID_W-1:0]       rsp_evicted_id_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic                  rsp_load;

   // entry memory ports
   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [ENT_W-1:0]      rd_data, wr_data;
   logic [ID_BITS-1:0]    rd_id;
   logic [TIME_W-1:0]     rd_time;
   logic [SIZE_BITS-1:0]  rd_size;

   // shared total add/subtract unit
   logic                  alu_sub;
   logic [SIZE_BITS-1:0]  alu_opnd;
   logic [SUM_W-1:0]      alu_a, alu_b, alu_sum, alu_diff;
   logic                  alu_borrow;
   logic [TOTAL_W-1:0]    alu_result;

   logic [CW-1:0]         cap_wide, cap_eff;
   logic                  full_now;
   logic                  time_ge;
   logic                  id_match;
   logic                  at_last;
   logic                  req_fire;

   bsl_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ENT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry layout: id on top, then time, then size
   assign rd_id   = rd_data[ENT_W-1 -: ID_BITS];
   assign rd_time = rd_data[SIZE_BITS +: TIME_W];
   assign rd_size = rd_data[SIZE_BITS-1:0];

   // capacity: zero acts as one, above depth acts as depth
   assign cap_wide = CW'(cap_ff);
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CW'(1);
      end else if (cap_wide > CW'(DEPTH)) begin
         cap_eff = CW'(DEPTH);
      end else begin
         cap_eff = cap_wide;
      end
   end
   assign full_now = CW'(count_ff) >= cap_eff;

   // subtract a stored size while scanning, add the new size on insert
   assign alu_sub  = (state_ff == S_ADD_SCAN) || (state_ff == S_REM_SCAN);
   assign alu_opnd = alu_sub ? rd_size : item_size_ff;

   // total update, saturating on add and clamping on subtract
   assign alu_a      = SUM_W'(total_ff);
   assign alu_b      = SUM_W'(alu_opnd);
   assign alu_sum    = alu_a + alu_b;
   assign alu_diff   = alu_a - alu_b;
   assign alu_borrow = alu_a < alu_b;
   always_comb begin
      if (alu_sub) begin
         alu_result = alu_borrow ? '0 : alu_diff[TOTAL_W-1:0];
      end else begin
         alu_result = (alu_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : alu_sum[TOTAL_W-1:0];
      end
   end

   // ties go newest first, so an equal time is inserted ahead
   assign time_ge  = $signed(item_time_ff) >= $signed(rd_time);
   assign id_match = rd_id == item_id_ff;
   assign at_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign req_fire = req_valid && req_ready;

   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      full_in      = full_ff;
      first_in     = first_ff;
      status_in    = status_ff;
      evicted_in   = evicted_ff;
      ev_id_in     = ev_id_ff;
      item_id_in   = item_id_ff;
      item_time_in = item_time_ff;
      item_size_in = item_size_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rsp_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_id_in   = ID_BITS'(req_item_id);
               item_time_in = req_item_time;
               item_size_in = SIZE_BITS'(req_item_size);
               status_in    = ST_OK;
               evicted_in   = 1'b0;
               ev_id_in     = '0;
               pos_in       = '0;
               full_in      = full_now;
               first_in     = 1'b1;
               if (req_action == ACT_ADD) begin
                  if (count_ff == '0) begin
                     // empty table: straight to the head
                     state_in = S_ADD_INS;
                  end else begin
                     // start the walk at the tail
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CNT_W'(1));
                     idx_in   = AW'(count_ff - CNT_W'(1));
                     state_in = S_ADD_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = S_REM_SCAN;
                  end
               end
            end
         end

         S_ADD_SCAN: begin
            first_in = 1'b0;
            if (first_ff && full_ff) begin
               if (!time_ge) begin
                  // would land past the tail of a full table
                  status_in = ST_DROP;
                  state_in  = S_FIN;
               end else begin
                  // push the tail entry out and keep walking
                  evicted_in = 1'b1;
                  ev_id_in   = rd_id;
                  total_in   = alu_result;
                  count_in   = count_ff - CNT_W'(1);
                  if (idx_ff == '0) begin
                     pos_in   = '0;
                     state_in = S_ADD_INS;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ff - AW'(1);
                     idx_in  = idx_ff - AW'(1);
                  end
               end
            end else if (time_ge) begin
               // older entry moves one slot down
               wr_en   = 1'b1;
               wr_addr = idx_ff + AW'(1);
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  pos_in   = '0;
                  state_in = S_ADD_INS;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end else begin
               pos_in   = idx_ff + AW'(1);
               state_in = S_ADD_INS;
            end
         end

         S_ADD_INS: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = {item_id_ff, item_time_ff, item_size_ff};
            total_in = alu_result;
            count_in = count_ff + CNT_W'(1);
            state_in = S_FIN;
         end

         S_REM_SCAN: begin
            if (id_match) begin
               pos_in    = idx_ff;
               total_in  = alu_result;
               status_in = alu_borrow ? ST_UNDERFLOW : ST_OK;
               if (at_last) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + AW'(1);
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_REM_SHIFT;
               end
            end else if (at_last) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FIN;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(1);
               idx_in  = idx_ff + AW'(1);
            end
         end

         S_REM_SHIFT: begin
            // close the gap one entry at a time
            wr_en   = 1'b1;
            wr_addr = idx_ff - AW'(1);
            wr_data = rd_data;
            if (at_last) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FIN;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(1);
               idx_in  = idx_ff + AW'(1);
            end
         end

         S_FIN: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cap_in       = (csr_valid && csr_ready) ? csr_capacity : cap_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         cap_ff       <= CAP_RESET;
         full_ff      <= 1'b0;
         first_ff     <= 1'b0;
         evicted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         cap_ff       <= cap_in;
         full_ff      <= full_in;
         first_ff     <= first_in;
         evicted_ff   <= evicted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      status_ff    <= status_in;
      ev_id_ff     <= ev_id_in;
      item_id_ff   <= item_id_in;
      item_time_ff <= item_time_in;
      item_size_ff <= item_size_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff     <= status_ff;
         rsp_position_ff   <= POS_W'(pos_ff);
         rsp_evicted_ff    <= evicted_ff;
         rsp_evicted_id_ff <= ID_W'(ev_id_ff);
         rsp_count_ff      <= COUNT_W'(count_ff);
         rsp_total_ff      <= total_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_id  = rsp_evicted_id_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_total_size  = rsp_total_ff;

   // memory writes stay inside the table
   `BSL_ASSERT_NOW(a_wr_in_range, wr_en, wr_addr <= AW'(DEPTH - 1))
   // count never passes the build depth
   `BSL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH))
   // a full table that keeps walking must have evicted its tail
   `BSL_ASSERT_NOW(a_evict_on_full, (state_ff == S_ADD_SCAN) && !first_ff && full_ff, evicted_ff)
   // an eviction only comes with a successful add
   `BSL_ASSERT_NOW(a_evict_ok, rsp_valid_ff && rsp_evicted_ff, rsp_status_ff == ST_OK)
   // evicted id reads zero when nothing was pushed out
   `BSL_ASSERT_NOW(a_evid_zero, rsp_valid_ff && !rsp_evicted_ff, rsp_evicted_id_ff == '0)
   // an add to an empty table goes straight to insertion
   `BSL_ASSERT_NEXT(a_empty_add, req_fire && (req_action == ACT_ADD) && (count_ff == '0), state_ff == S_ADD_INS)

endmodule
